@@ rtl/core/gb3_pkg.sv @@
// ----------------------------------------------------------------------------
// gb3_pkg
// Types, constants and kernel arithmetic shared by the 3x3 binomial blur.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int PixW = 16;
  localparam int CfgW = 11;
  localparam int PosW = 10;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [8:0][PixW-1:0] win_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [CfgW-1:0] cfg_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam cfg_t WidthReset  = 11'd1000;
  localparam cfg_t HeightReset = 11'd1000;

  typedef struct packed {
    logic emit_main;
    logic emit_edge;
    logic last;
    pos_t col;
    pos_t row;
  } item_ctl_t;

  function automatic pix_t blur9(win_t v);
    logic [PixW+3:0] sum;
    sum = (PixW+4)'(v[0])
        + ((PixW+4)'(v[1]) << 1)
        + (PixW+4)'(v[2])
        + ((PixW+4)'(v[3]) << 1)
        + ((PixW+4)'(v[4]) << 2)
        + ((PixW+4)'(v[5]) << 1)
        + (PixW+4)'(v[6])
        + ((PixW+4)'(v[7]) << 1)
        + (PixW+4)'(v[8]);
    return sum[PixW+3:4];
  endfunction

  function automatic win_t edge_win(win_t v);
    win_t e;
    for (int i = 0; i < 3; i++) begin
      e[i*3]   = v[i*3+1];
      e[i*3+1] = v[i*3+2];
      e[i*3+2] = '0;
    end
    return e;
  endfunction

endpackage

@@ rtl/core/gaussian_blur_3x3.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_3x3
// Streaming 3x3 binomial blur of 16-bit raster pixels with zero borders.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and gives blurred pixel (r-1, c-1)
// when input (r, c) is taken; at each row end a second word, pixel (r-1, W-1),
// follows. That word waits in a hold register and leaves in the slot of the
// first pixel of the next row, which gives no word, so rows stream at one
// word per clock and the input stalls only as a result of output stalls.
// After the frame the source sends one drain row to flush the last image row;
// last marks the final word of the frame. Both line stores share one 32-bit
// wide RAM with a registered read, read when a pixel is taken and written back
// when that pixel moves into the window. The RAM needs no clearing pass after
// reset. Between an input word being taken and its output word lie the stage-1
// registers, the window register and the output register.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  gb3_pkg::cfg_t cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gb3_pkg::pix_t pixel_in_i,
  input  logic          drain_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gb3_pkg::pix_t pixel_out_o,
  output gb3_pkg::pos_t out_column_o,
  output gb3_pkg::pos_t out_row_o,
  output logic          last_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = ($clog2(MAX_WIDTH + 1) > gb3_pkg::CfgW) ?
                        $clog2(MAX_WIDTH + 1) : gb3_pkg::CfgW;
  localparam int YW   = ($clog2(MAX_HEIGHT + 1) > gb3_pkg::CfgW) ?
                        $clog2(MAX_HEIGHT + 1) : gb3_pkg::CfgW;
  localparam int PixW = gb3_pkg::PixW;

  gb3_pkg::cfg_t      width_q, height_q;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [XW-1:0]      w_raw, w_eff, col_x;
  logic [YW-1:0]      h_raw, h_eff, row_y, row_m1;
  logic               row_end, drain_row, in_accept;
  gb3_pkg::pix_t      px;
  gb3_pkg::item_ctl_t ctl;

  logic               s1_valid_q, s1_valid_d;
  logic [ColW-1:0]    s1_col_q;
  logic               s1_ge1_q, s1_ge2_q;
  gb3_pkg::pix_t      s1_px_q;
  gb3_pkg::item_ctl_t s1_ctl_q;
  logic               s1_adv, s2_free;

  logic [2*PixW-1:0]  ram_rdata, ram_wdata;
  gb3_pkg::pix_t      top, mid;
  gb3_pkg::win_t      window;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gb3_pkg::WidthReset;
      height_q <= gb3_pkg::HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gb3_pkg::cfg_reg_e'(cfg_index_i))
        gb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        gb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = XW'(width_q);
    h_raw = YW'(height_q);
    if (w_raw < XW'(2)) begin
      w_eff = XW'(2);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < YW'(1)) begin
      h_eff = YW'(1);
    end else if (h_raw > YW'(MAX_HEIGHT)) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  assign col_x     = XW'(col_q);
  assign row_y     = YW'(row_q);
  assign row_m1    = row_y - YW'(1);
  assign row_end   = col_x >= (w_eff - XW'(1));
  assign drain_row = row_y >= h_eff;
  assign px        = (drain_row || drain_i) ? '0 : pixel_in_i;

  always_comb begin
    ctl.emit_main = (row_q != '0) && (col_q != '0);
    ctl.emit_edge = row_end && (row_q != '0);
    ctl.last      = drain_row;
    ctl.col       = col_x[gb3_pkg::PosW-1:0];
    ctl.row       = row_m1[gb3_pkg::PosW-1:0];
  end

  assign s1_adv     = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = drain_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q <= col_q;
      s1_ge1_q <= row_q != '0;
      s1_ge2_q <= row_q > RowW'(1);
      s1_px_q  <= px;
      s1_ctl_q <= ctl;
    end
  end

  assign ram_wdata = {ram_rdata[PixW-1:0], s1_px_q};

  gb3_ram #(
    .Width(2 * PixW),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(ram_wdata),
    .re_i   (in_accept),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  assign top = s1_ge2_q ? ram_rdata[2*PixW-1:PixW] : '0;
  assign mid = s1_ge1_q ? ram_rdata[PixW-1:0] : '0;

  gb3_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .col_zero_i(s1_col_q == '0),
    .top_i     (top),
    .mid_i     (mid),
    .px_i      (s1_px_q),
    .window_o  (window)
  );

  gb3_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv),
    .ctl_i       (s1_ctl_q),
    .window_i    (window),
    .free_o      (s2_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .out_column_o(out_column_o),
    .out_row_o   (out_row_o),
    .last_o      (last_o)
  );

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && row_end |=> col_q == '0)
    else $error("column counter did not wrap at row end");

  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && in_accept |-> s1_col_q != col_q)
    else $error("line RAM read and write hit the same column");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_px_q))
    else $error("stalled pixel left the window stage");

endmodule

@@ rtl/core/gb3_ram.sv @@
// ----------------------------------------------------------------------------
// gb3_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gb3_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/gb3_window.sv @@
// ----------------------------------------------------------------------------
// gb3_window
// The 3x3 pixel window, shifted by one column per pixel and cleared on the
// left image edge.
// ----------------------------------------------------------------------------
module gb3_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          col_zero_i,
  input  gb3_pkg::pix_t top_i,
  input  gb3_pkg::pix_t mid_i,
  input  gb3_pkg::pix_t px_i,
  output gb3_pkg::win_t window_o
);

  gb3_pkg::win_t window_q, window_d;

  always_comb begin
    window_d = window_q;
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        if (col_zero_i) begin
          window_d[i*3]   = '0;
          window_d[i*3+1] = '0;
        end else begin
          window_d[i*3]   = window_q[i*3+1];
          window_d[i*3+1] = window_q[i*3+2];
        end
      end
      window_d[2] = top_i;
      window_d[5] = mid_i;
      window_d[8] = px_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else begin
      window_q <= window_d;
    end
  end

  assign window_o = window_q;

endmodule

@@ rtl/core/gb3_emit.sv @@
// ----------------------------------------------------------------------------
// gb3_emit
// Computes the blurred pixels of one window and sends up to two words per
// pixel through the output register, with a hold register for the row-end
// word.
// ----------------------------------------------------------------------------
module gb3_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  gb3_pkg::item_ctl_t  ctl_i,
  input  gb3_pkg::win_t       window_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gb3_pkg::pix_t       pixel_out_o,
  output gb3_pkg::pos_t       out_column_o,
  output gb3_pkg::pos_t       out_row_o,
  output logic                last_o
);

  logic               pend_main_q, pend_main_d;
  logic               pend_edge_q, pend_edge_d;
  gb3_pkg::item_ctl_t ctl_q;
  logic               hold_valid_q, hold_valid_d;
  gb3_pkg::pix_t      hold_pix_q, hold_pix_d;
  gb3_pkg::pos_t      hold_col_q, hold_col_d;
  gb3_pkg::pos_t      hold_row_q, hold_row_d;
  logic               hold_last_q, hold_last_d;
  logic               out_valid_q, out_valid_d;
  gb3_pkg::pix_t      pix_q, pix_d;
  gb3_pkg::pos_t      col_q, col_d;
  gb3_pkg::pos_t      row_q, row_d;
  logic               last_q, last_d;
  gb3_pkg::pix_t      main_pix, edge_pix;
  logic               out_free;
  logic               push_hold, push_main, push_edge;
  logic               main_done, hold_free, move_edge;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign push_hold = out_free && hold_valid_q;
  assign push_main = out_free && !hold_valid_q && pend_main_q;
  assign push_edge = out_free && !hold_valid_q && !pend_main_q && pend_edge_q;
  assign main_done = !pend_main_q || push_main;
  assign hold_free = !hold_valid_q || push_hold;
  assign move_edge = pend_edge_q && !push_edge && main_done && hold_free;
  assign free_o    = main_done && (!pend_edge_q || push_edge || move_edge);
  assign main_pix  = gb3_pkg::blur9(window_i);
  assign edge_pix  = gb3_pkg::blur9(gb3_pkg::edge_win(window_i));

  always_comb begin
    pend_main_d  = pend_main_q && !push_main;
    pend_edge_d  = pend_edge_q && !(push_edge || move_edge);
    hold_valid_d = hold_valid_q && !push_hold;
    hold_pix_d   = hold_pix_q;
    hold_col_d   = hold_col_q;
    hold_row_d   = hold_row_q;
    hold_last_d  = hold_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    pix_d        = pix_q;
    col_d        = col_q;
    row_d        = row_q;
    last_d       = last_q;
    if (move_edge) begin
      hold_valid_d = 1'b1;
      hold_pix_d   = edge_pix;
      hold_col_d   = ctl_q.col;
      hold_row_d   = ctl_q.row;
      hold_last_d  = ctl_q.last;
    end
    if (push_hold) begin
      out_valid_d = 1'b1;
      pix_d       = hold_pix_q;
      col_d       = hold_col_q;
      row_d       = hold_row_q;
      last_d      = hold_last_q;
    end else if (push_main) begin
      out_valid_d = 1'b1;
      pix_d       = main_pix;
      col_d       = ctl_q.col - gb3_pkg::pos_t'(1);
      row_d       = ctl_q.row;
      last_d      = 1'b0;
    end else if (push_edge) begin
      out_valid_d = 1'b1;
      pix_d       = edge_pix;
      col_d       = ctl_q.col;
      row_d       = ctl_q.row;
      last_d      = ctl_q.last;
    end
    if (load_i) begin
      pend_main_d = ctl_i.emit_main;
      pend_edge_d = ctl_i.emit_edge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_main_q  <= 1'b0;
      pend_edge_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_main_q  <= pend_main_d;
      pend_edge_q  <= pend_edge_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_q <= ctl_i;
    end
    hold_pix_q  <= hold_pix_d;
    hold_col_q  <= hold_col_d;
    hold_row_q  <= hold_row_d;
    hold_last_q <= hold_last_d;
    pix_q       <= pix_d;
    col_q       <= col_d;
    row_q       <= row_d;
    last_q      <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_q;
  assign out_column_o = col_q;
  assign out_row_o    = row_q;
  assign last_o       = last_q;

endmodule
